/* design/rau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int RES_NUM_W     = 34;
   localparam int RES_DEN_W     = 33;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int MAG_W         = 2 * OPERAND_WIDTH;
   localparam int VAL_W         = MAG_W + 1;
   localparam int CNT_W         = $clog2(MAG_W);

   typedef enum logic [1:0] {
      CMD_ADD,
      CMD_SUB,
      CMD_MUL,
      CMD_DIV
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_T0,
      ST_MUL_T1,
      ST_MUL_RD,
      ST_MUL_END,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DIVN_GO,
      ST_DIVN_WAIT,
      ST_DIVD_GO,
      ST_DIVD_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        [1:0]               command;
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [RES_NUM_W-1:0] result_num;
      logic        [RES_DEN_W-1:0] result_den;
   } rsp_type;

endpackage

`default_nettype wire

/* design/rau_gcd.sv */
`timescale 1ns / 1ps
`default_nettype none

module rau_gcd (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [rau_pkg::MAG_W-1:0] op_a,
   input  wire logic [rau_pkg::MAG_W-1:0] op_b,
   output logic                         done,
   output logic [rau_pkg::MAG_W-1:0]    result
);
   import rau_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [MAG_W-1:0] u_ff;
   logic [MAG_W-1:0] u_in;
   logic [MAG_W-1:0] v_ff;
   logic [MAG_W-1:0] v_in;
   logic [CNT_W-1:0] k_ff;
   logic [CNT_W-1:0] k_in;
   logic [MAG_W-1:0] result_ff;
   logic             finish;

   assign finish = busy_ff && ((u_ff == '0) || (v_ff == '0));

   // One binary gcd step: halve whatever is even, otherwise halve the difference.
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = CNT_W'(k_ff + 1'b1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = (u_ff - v_ff) >> 1;
      end else begin
         v_in = (v_ff - u_ff) >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= finish;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         u_ff <= op_a;
         v_ff <= op_b;
         k_ff <= '0;
      end else if (busy_ff && !finish) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (finish) begin
         result_ff <= (u_ff | v_ff) << k_ff;
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

/* design/rau_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module rau_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rau_pkg::MAG_W-1:0] dividend,
   input  wire logic [rau_pkg::MAG_W-1:0] divisor,
   output logic                           done,
   output logic [rau_pkg::MAG_W-1:0]      quotient
);
   import rau_pkg::*;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [MAG_W-1:0] rem_ff;
   logic [MAG_W-1:0] rem_in;
   logic [MAG_W-1:0] quo_ff;
   logic [MAG_W-1:0] quo_in;
   logic [MAG_W-1:0] dvs_ff;
   logic [MAG_W:0]   rem_shift;
   logic [MAG_W-1:0] rem_diff;
   logic             fits;

   // Restoring division: the dividend shifts out of quo_ff as quotient bits shift in.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[MAG_W-1]};
      rem_diff  = rem_shift[MAG_W-1:0] - dvs_ff;
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_in    = fits ? rem_diff : rem_shift[MAG_W-1:0];
      quo_in    = {quo_ff[MAG_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(MAG_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= CNT_W'(cnt_ff - 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* design/rational_arith_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Exact arithmetic on two signed fractions, returned in lowest terms.
// A transaction on the req_ channel carries a command (add, subtract, multiply,
// divide) and two fractions; a zero denominator is read as one. Each request
// gives exactly one transaction on the rsp_ channel: the reduced numerator, which
// carries the sign, over a positive denominator. Dividing by a zero fraction
// gives the first operand's reduced numerator over one.
// One request is in flight at a time, and req_stall is high from acceptance
// until the result has been moved into the output register. A request runs
// through products on the shared multiplier, then a data-dependent binary gcd,
// one step per cycle, then two restoring divisions by the gcd on a single
// divider. A new request is taken in the cycle after the result is loaded.
// The output register holds the result while rsp_stall is high, and a new
// request is accepted meanwhile; the next result waits in the unit until the
// register is free. Synchronous reset empties the output register and returns
// the sequencer to idle; nothing else is kept between transactions.
module rational_arith_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rau_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rau_pkg::rsp_type      rsp_data
);
   import rau_pkg::*;

   state_type state_ff;
   state_type state_in;

   cmd_type                         cmd_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff;
   logic signed [OPERAND_WIDTH-1:0] ad_ff;
   logic signed [OPERAND_WIDTH-1:0] bn_ff;
   logic signed [OPERAND_WIDTH-1:0] bd_ff;
   logic                            force_ff;
   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [VAL_W-1:0]         num_ff;
   logic signed [VAL_W-1:0]         den_ff;
   logic [MAG_W-1:0]                g_ff;
   logic [MAG_W-1:0]                qn_ff;
   logic                            rsp_valid_ff;
   rsp_type                         rsp_data_ff;
   rsp_type                         rsp_data_in;

   logic signed [OPERAND_WIDTH-1:0] mul_x;
   logic signed [OPERAND_WIDTH-1:0] mul_y;
   logic signed [PROD_W-1:0]        mul_prod;
   logic [MAG_W-1:0]                num_mag;
   logic [MAG_W-1:0]                den_mag;
   logic [MAG_W-1:0]                div_dividend;
   logic [MAG_W-1:0]                div_quotient;
   logic [MAG_W-1:0]                gcd_result;
   logic signed [VAL_W-1:0]         qn_signed;
   logic signed [VAL_W-1:0]         res_num;
   logic                            accept;
   logic                            load_rsp;
   logic                            gcd_start;
   logic                            gcd_done;
   logic                            div_start;
   logic                            div_done;

   localparam logic signed [OPERAND_WIDTH-1:0] ONE_OP = OPERAND_WIDTH'(1);

   assign accept   = req_valid && !req_stall;
   assign mul_prod = mul_x * mul_y;
   assign num_mag  = num_ff[VAL_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
   assign den_mag  = den_ff[VAL_W-1] ? MAG_W'(-den_ff) : MAG_W'(den_ff);

   rau_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .op_a   (num_mag),
      .op_b   (den_mag),
      .done   (gcd_done),
      .result (gcd_result)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL_T0;
            end
         end
         ST_MUL_T0:  state_in = ST_MUL_T1;
         ST_MUL_T1:  state_in = ST_MUL_RD;
         ST_MUL_RD:  state_in = ST_MUL_END;
         ST_MUL_END: state_in = ST_GCD_GO;
         ST_GCD_GO:  state_in = ST_GCD_WAIT;
         ST_GCD_WAIT: begin
            if (gcd_done) begin
               state_in = ST_DIVN_GO;
            end
         end
         ST_DIVN_GO: state_in = ST_DIVN_WAIT;
         ST_DIVN_WAIT: begin
            if (div_done) begin
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: state_in = ST_DIVD_WAIT;
         ST_DIVD_WAIT: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      gcd_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = num_mag;
      load_rsp     = 1'b0;
      mul_x        = '0;
      mul_y        = '0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_MUL_T0: begin
            mul_x = an_ff;
            if (cmd_ff == CMD_MUL) begin
               mul_y = bn_ff;
            end else begin
               mul_y = force_ff ? ONE_OP : bd_ff;
            end
         end
         ST_MUL_T1: begin
            if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
               mul_x = bn_ff;
               mul_y = ad_ff;
            end
         end
         ST_MUL_RD: begin
            mul_x = ad_ff;
            if (cmd_ff == CMD_DIV) begin
               mul_y = force_ff ? ONE_OP : bn_ff;
            end else begin
               mul_y = bd_ff;
            end
         end
         ST_GCD_GO:  gcd_start = 1'b1;
         ST_DIVN_GO: div_start = 1'b1;
         ST_DIVD_GO: begin
            div_start    = 1'b1;
            div_dividend = den_mag;
         end
         ST_OUT: load_rsp = !rsp_valid_ff || !rsp_stall;
         default: begin
         end
      endcase
   end

   always_comb begin
      qn_signed              = signed'({1'b0, qn_ff});
      res_num                = (num_ff[VAL_W-1] ^ den_ff[VAL_W-1]) ? -qn_signed : qn_signed;
      rsp_data_in.result_num = RES_NUM_W'(res_num);
      rsp_data_in.result_den = force_ff ? RES_DEN_W'(1) : RES_DEN_W'(div_quotient);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_data.command);
         an_ff    <= req_data.a_num;
         ad_ff    <= (req_data.a_den == '0) ? ONE_OP : req_data.a_den;
         bn_ff    <= req_data.b_num;
         bd_ff    <= (req_data.b_den == '0) ? ONE_OP : req_data.b_den;
         force_ff <= (cmd_type'(req_data.command) == CMD_DIV) && (req_data.b_num == '0);
      end
      prod_ff <= mul_prod;
      case (state_ff)
         ST_MUL_T1: num_ff <= VAL_W'(prod_ff);
         ST_MUL_RD: begin
            if (cmd_ff == CMD_SUB) begin
               num_ff <= num_ff - VAL_W'(prod_ff);
            end else begin
               num_ff <= num_ff + VAL_W'(prod_ff);
            end
         end
         ST_MUL_END: den_ff <= VAL_W'(prod_ff);
         ST_GCD_WAIT: begin
            if (gcd_done) begin
               g_ff <= gcd_result;
            end
         end
         ST_DIVN_WAIT: begin
            if (div_done) begin
               qn_ff <= div_quotient;
            end
         end
         default: begin
         end
      endcase
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_den != '0)
      else $error("Result denominator is zero.");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> gcd_result != '0)
      else $error("Gcd of a nonzero denominator came out zero.");

   a_gcd_expected: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> state_ff == ST_GCD_WAIT)
      else $error("Gcd finished while the sequencer was not waiting for it.");

   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVN_WAIT || state_ff == ST_DIVD_WAIT))
      else $error("Divider finished while the sequencer was not waiting for it.");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("Loaded result did not appear on the response channel.");

endmodule

`default_nettype wire
